// File: rtl/segl_pkg.sv
// Shared types, command codes and segment tables for the segment LCD loader.
// Depends on nothing; every other file in this folder but segl_if refers to it by scoped names.
package segl_pkg;

    typedef enum logic [2:0] {
        CMD_FILL    = 3'd0,
        CMD_CLEAR   = 3'd1,
        CMD_HEX     = 3'd2,
        CMD_DECIMAL = 3'd3,
        CMD_ONES    = 3'd4,
        CMD_TENS    = 3'd5,
        CMD_REFRESH = 3'd6
    } t_cmd;

    // Snapshot of the segment image that a refresh shifts out.
    typedef struct packed {
        logic [4:0] high5;
        logic [7:0] mid;
        logic [7:0] low;
    } t_frame;

    // Fill state of the frame queue, seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam logic [7:0] CLR_MASK_LOW   = 8'h8f;
    localparam logic [7:0] CLR_MASK_MID   = 8'h20;
    localparam logic [4:0] HIGH_FORCE     = 5'h10;
    localparam logic [7:0] DIV10_RECIP    = 8'd205;  // value * 205 >> 11 == value / 10
    localparam int         DIV10_SHIFT    = 11;
    localparam logic [4:0] FRAME_LAST     = 5'd22;

    // Ones digit patterns as {byte0, byte1, byte2}.
    function automatic logic [23:0] ones_seg(input logic [3:0] digit);
        logic [23:0] r;
        case (digit)
            4'd0:    r = 24'h005c03;
            4'd1:    r = 24'h004001;
            4'd2:    r = 24'h009803;
            4'd3:    r = 24'h00d003;
            4'd4:    r = 24'h00c401;
            4'd5:    r = 24'h00d402;
            4'd6:    r = 24'h00dc02;
            4'd7:    r = 24'h004003;
            4'd8:    r = 24'h00dc03;
            4'd9:    r = 24'h00d403;
            4'd10:   r = 24'h00cc03;
            4'd11:   r = 24'h00dc00;
            4'd12:   r = 24'h001c02;
            4'd13:   r = 24'h00d801;
            4'd14:   r = 24'h009c02;
            default: r = 24'h008c02;
        endcase
        return r;
    endfunction

    // Tens digit patterns as {byte0, byte1, byte2}.
    function automatic logic [23:0] tens_seg(input logic [3:0] digit);
        logic [23:0] r;
        case (digit)
            4'd0:    r = 24'h700304;
            4'd1:    r = 24'h400004;
            4'd2:    r = 24'h10030c;
            4'd3:    r = 24'h50010c;
            4'd4:    r = 24'h60000c;
            4'd5:    r = 24'h700108;
            4'd6:    r = 24'h700308;
            4'd7:    r = 24'h500004;
            4'd8:    r = 24'h70030c;
            4'd9:    r = 24'h70010c;
            4'd10:   r = 24'h70020c;
            4'd11:   r = 24'h600308;
            4'd12:   r = 24'h300300;
            4'd13:   r = 24'h40030c;
            4'd14:   r = 24'h300308;
            default: r = 24'h300208;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/segl_if.sv
// Valid/ready channel interfaces for the command input and the serial output.
// Depends on nothing; used by the front end, the serializer and the top level.
interface segl_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] value;
    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface segl_seg_if;
    logic valid;
    logic ready;
    logic serial_data;
    logic chip_enable;
    logic load_pulse;
    logic frame_end;
    modport source (output valid, output serial_data, output chip_enable,
                    output load_pulse, output frame_end, input ready);
    modport sink   (input valid, input serial_data, input chip_enable,
                    input load_pulse, input frame_end, output ready);
endinterface

// File: rtl/segl_front.sv
// Command front end: holds the segment image, executes buffer commands and
// pushes refresh snapshots into the frame queue. Depends on segl_pkg, segl_if.
module segl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    segl_cmd_if.sink          i_cmd,
    input  segl_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output segl_pkg::t_frame  o_frame
);

    logic [7:0]  r_low, r_mid, r_high;
    logic [7:0]  n_low, n_mid, n_high;
    logic        accept;
    logic        is_refresh;
    logic [15:0] prod;
    logic [4:0]  quot;
    logic [7:0]  quot_x10;
    logic [7:0]  rem;
    logic [23:0] add_bits;

    assign is_refresh  = (i_cmd.cmd == segl_pkg::CMD_REFRESH);
    assign i_cmd.ready = !is_refresh || !i_q_stat.full;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Division by ten through a reciprocal; exact for every 8-bit value.
    assign prod     = i_cmd.value * segl_pkg::DIV10_RECIP;
    assign quot     = prod[15:segl_pkg::DIV10_SHIFT];
    assign quot_x10 = {quot[4:0], 3'b000} + {2'b00, quot[4:0], 1'b0};
    assign rem      = i_cmd.value - quot_x10;

    always_comb begin
        add_bits = 24'h000000;
        case (i_cmd.cmd)
            segl_pkg::CMD_HEX: begin
                add_bits = segl_pkg::ones_seg(i_cmd.value[3:0])
                         | segl_pkg::tens_seg(i_cmd.value[7:4]);
            end
            segl_pkg::CMD_DECIMAL: begin
                // Values of 160 or more have no tens pattern.
                add_bits = segl_pkg::ones_seg(rem[3:0]);
                if (!quot[4]) begin
                    add_bits = add_bits | segl_pkg::tens_seg(quot[3:0]);
                end
            end
            segl_pkg::CMD_ONES: begin
                if (i_cmd.value[7:4] == 4'd0) begin
                    add_bits = segl_pkg::ones_seg(i_cmd.value[3:0]);
                end
            end
            segl_pkg::CMD_TENS: begin
                if (i_cmd.value[7:4] == 4'd0) begin
                    add_bits = segl_pkg::tens_seg(i_cmd.value[3:0]);
                end
            end
            default: begin
                add_bits = 24'h000000;
            end
        endcase
    end

    always_comb begin
        n_low  = r_low;
        n_mid  = r_mid;
        n_high = r_high;
        if (accept) begin
            unique case (i_cmd.cmd) inside
                segl_pkg::CMD_FILL: begin
                    n_low  = i_cmd.value;
                    n_mid  = i_cmd.value;
                    n_high = i_cmd.value;
                end
                segl_pkg::CMD_CLEAR: begin
                    n_low  = r_low & segl_pkg::CLR_MASK_LOW;
                    n_mid  = r_mid & segl_pkg::CLR_MASK_MID;
                    n_high = 8'h00;
                end
                segl_pkg::CMD_HEX, segl_pkg::CMD_DECIMAL,
                segl_pkg::CMD_ONES, segl_pkg::CMD_TENS: begin
                    n_low  = r_low  | add_bits[23:16];
                    n_mid  = r_mid  | add_bits[15:8];
                    n_high = r_high | add_bits[7:0];
                end
                default: begin
                    n_low  = r_low;
                    n_mid  = r_mid;
                    n_high = r_high;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 8'h00;
            r_mid  <= 8'h00;
            r_high <= 8'h00;
        end else begin
            r_low  <= n_low;
            r_mid  <= n_mid;
            r_high <= n_high;
        end
    end

    assign o_push        = accept && is_refresh;
    assign o_frame.low   = r_low;
    assign o_frame.mid   = r_mid;
    assign o_frame.high5 = r_high[4:0] | segl_pkg::HIGH_FORCE;

endmodule

// File: rtl/segl_fifo.sv
// Small queue of refresh snapshots between the front end and the serializer.
// Depends on segl_pkg for the frame and status types.
module segl_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  segl_pkg::t_frame  i_frame,
    input  logic              i_pop,
    output segl_pkg::t_frame  o_frame,
    output segl_pkg::t_q_stat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    segl_pkg::t_frame r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_frame      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/segl_ser.sv
// Serializer: takes one snapshot at a time and emits the 23 items of a frame
// through a registered output stage. Depends on segl_pkg and segl_if.
module segl_ser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  segl_pkg::t_frame  i_frame,
    input  segl_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    segl_seg_if.source        o_seg
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [21:0] r_shift;
    logic        r_valid;
    logic        r_data, r_ce, r_load, r_end;
    logic        advance;
    logic        is_last;

    assign advance = !r_valid || o_seg.ready;
    assign is_last = (r_cnt == segl_pkg::FRAME_LAST);
    assign o_pop   = !r_busy && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            if (!r_busy) begin
                if (!i_q_stat.empty) begin
                    r_busy <= 1'b1;
                    r_cnt  <= 5'd0;
                end
            end else if (advance) begin
                r_cnt <= r_cnt + 5'd1;
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_valid <= r_busy;
            end
        end
    end

    // Payload path: the leading zero bit sits at the bottom of the shift word.
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_shift <= {i_frame.high5, i_frame.mid, i_frame.low, 1'b0};
        end else if (advance) begin
            r_shift <= {1'b0, r_shift[21:1]};
        end
        if (advance) begin
            r_data <= is_last ? 1'b0 : r_shift[0];
            r_ce   <= !is_last;
            r_load <= is_last;
            r_end  <= is_last;
        end
    end

    assign o_seg.valid       = r_valid;
    assign o_seg.serial_data = r_data;
    assign o_seg.chip_enable = r_ce;
    assign o_seg.load_pulse  = r_load;
    assign o_seg.frame_end   = r_end;

endmodule

// File: rtl/segment_lcd_buffer_and_serial_loader_core.sv
// Top level of the segment LCD buffer and serial loader.
// Depends on segl_pkg, segl_if, segl_front, segl_fifo and segl_ser.
//
// Usage: commands arrive on i_cmd (valid/ready, fields cmd and value). Fill,
// clear and the print commands update the three-byte segment image in the
// cycle they are accepted and produce no output items; one can be accepted
// every cycle regardless of what the serial side is doing.
// A refresh takes a snapshot of the image into a queue of QUEUE_DEPTH frames.
// The serializer drains that queue and emits 23 items per frame on o_seg:
// a leading zero bit, byte0 and byte1 LSB first, five bits of byte2 with bit 4
// forced high, all with chip_enable high, and finally a load item with
// chip_enable low, load_pulse high and frame_end high.
// When the serializer was idle, the first item of an accepted refresh passes
// through the snapshot queue, the serializer's shift register and the output
// register. Back-to-back frames leave a gap on the output while the serializer
// fetches the next snapshot; it takes none until a frame is out, and it is the limit.
// When the receiver holds ready low, the output register and the serializer
// hold their place; buffer commands keep flowing, and refresh commands are
// held off only once the snapshot queue is full.
// Reset (synchronous, active low) clears the image to zero, empties the queue
// and drops o_seg.valid.
module segment_lcd_buffer_and_serial_loader_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    segl_cmd_if.sink    i_cmd,
    segl_seg_if.source  o_seg
);

    logic              push;
    logic              pop;
    segl_pkg::t_frame  front_frame;
    segl_pkg::t_frame  queue_frame;
    segl_pkg::t_q_stat q_stat;

    // Front end: executes buffer commands and snapshots the image on refresh.
    segl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_frame  (front_frame)
    );

    // Snapshot queue decoupling the command side from the serial side.
    segl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .i_pop   (pop),
        .o_frame (queue_frame),
        .o_stat  (q_stat)
    );

    // Serializer with its registered output stage.
    segl_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (queue_frame),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_seg    (o_seg)
    );

endmodule

// File: tb/segl_frame_monitor.sv
`timescale 1ns / 1ps
// Watches the command and serial channels of the segment LCD loader, keeps its own segment image
// and compares every serial item with the one the image predicts. Depends on segl_pkg and segl_if.
module segl_frame_monitor (
    input  logic  i_clk,
    input  logic  i_rst_n,
    segl_cmd_if   i_cmd_bus,
    segl_seg_if   i_seg_bus,
    output int    o_mismatch_count,
    output int    o_owed_items
);

    typedef struct packed {
        logic serial_data;
        logic chip_enable;
        logic load_pulse;
        logic frame_end;
    } t_seg_item;

    // Patterns as {byte0, byte1, byte2}, digit 15 in the top slot and digit 0 at the bottom.
    localparam logic [16*24-1:0] ONES_ROM = {
        24'h008c02, 24'h009c02, 24'h00d801, 24'h001c02, 24'h00dc00, 24'h00cc03, 24'h00d403,
        24'h00dc03, 24'h004003, 24'h00dc02, 24'h00d402, 24'h00c401, 24'h00d003, 24'h009803,
        24'h004001, 24'h005c03
    };
    localparam logic [16*24-1:0] TENS_ROM = {
        24'h300208, 24'h300308, 24'h40030c, 24'h300300, 24'h600308, 24'h70020c, 24'h70010c,
        24'h70030c, 24'h500004, 24'h700308, 24'h700108, 24'h60000c, 24'h50010c, 24'h10030c,
        24'h400004, 24'h700304
    };

    logic [7:0] image_low, image_mid, image_high;
    t_seg_item  frame_q[$];
    int         mismatches = 0;

    // Digit codes above fifteen leave the image untouched.
    task automatic or_digit(input bit use_tens, input int digit);
        logic [23:0] pat;
        if (digit >= 0 && digit <= 15) begin
            pat = use_tens ? TENS_ROM[digit*24 +: 24] : ONES_ROM[digit*24 +: 24];
            image_low  = image_low  | pat[23:16];
            image_mid  = image_mid  | pat[15:8];
            image_high = image_high | pat[7:0];
        end
    endtask

    task automatic push_bits(input logic [7:0] bits, input int count);
        t_seg_item it;
        for (int b = 0; b < count; b++) begin
            it = '{serial_data: bits[b], chip_enable: 1'b1, load_pulse: 1'b0, frame_end: 1'b0};
            frame_q.push_back(it);
        end
    endtask

    task automatic apply_command(input logic [2:0] code, input logic [7:0] value);
        case (segl_pkg::t_cmd'(code))
            segl_pkg::CMD_FILL: begin
                image_low  = value;
                image_mid  = value;
                image_high = value;
            end
            segl_pkg::CMD_CLEAR: begin
                image_low  = image_low & 8'h8f;
                image_mid  = image_mid & 8'h20;
                image_high = 8'h00;
            end
            segl_pkg::CMD_HEX: begin
                or_digit(1'b0, int'(value[3:0]));
                or_digit(1'b1, int'(value[7:4]));
            end
            segl_pkg::CMD_DECIMAL: begin
                or_digit(1'b1, int'(value) / 10);
                or_digit(1'b0, int'(value) % 10);
            end
            segl_pkg::CMD_ONES: or_digit(1'b0, int'(value));
            segl_pkg::CMD_TENS: or_digit(1'b1, int'(value));
            segl_pkg::CMD_REFRESH: begin
                push_bits(8'h00, 1);
                push_bits(image_low, 8);
                push_bits(image_mid, 8);
                push_bits({3'b000, image_high[4:0] | 5'h10}, 5);
                frame_q.push_back('{serial_data: 1'b0, chip_enable: 1'b0,
                                    load_pulse: 1'b1, frame_end: 1'b1});
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_seg_item want, got;
        if (!i_rst_n) begin
            image_low  = 8'h00;
            image_mid  = 8'h00;
            image_high = 8'h00;
            frame_q.delete();
        end else begin
            if (i_cmd_bus.valid && i_cmd_bus.ready)
                apply_command(i_cmd_bus.cmd, i_cmd_bus.value);
            if (i_seg_bus.valid && i_seg_bus.ready) begin
                got = '{serial_data: i_seg_bus.serial_data, chip_enable: i_seg_bus.chip_enable,
                        load_pulse: i_seg_bus.load_pulse, frame_end: i_seg_bus.frame_end};
                if (frame_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 100)
                        $display("%0t: serial item with nothing expected: expected none, got %b",
                                 $time, got);
                end else begin
                    want = frame_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 100)
                            $display("%0t: serial item {data,ce,load,end} expected %b, got %b",
                                     $time, want, got);
                    end
                end
            end
        end
        o_mismatch_count = mismatches;
        o_owed_items     = frame_q.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the segment LCD loader testbench: clock, reset, command stimulus and receiver stalls.
// Depends on segl_pkg, segl_if, the core and segl_frame_monitor, which does all the checking.
module testbench;

    // The one command code that the block has no use for.
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_ITEMS = 470;

    logic i_clk = 1'b0;
    logic i_rst_n;

    segl_cmd_if cmd_bus ();
    segl_seg_if seg_bus ();

    int mismatch_count;
    int owed_items;
    int cycle_count = 0;
    int items_sent = 0;
    int burst_left = 0;

    always #2 i_clk = ~i_clk;

    segment_lcd_buffer_and_serial_loader_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_seg   (seg_bus)
    );

    segl_frame_monitor u_frame_monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_bus        (cmd_bus),
        .i_seg_bus        (seg_bus),
        .o_mismatch_count (mismatch_count),
        .o_owed_items     (owed_items)
    );

    // A run that never drains ends here instead of hanging.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("segment_lcd_buffer_and_serial_loader_core regression: fail");
            $finish;
        end
    end

    // The receiver switches now and then at random between stall patterns: always ready,
    // coin flips, long stalls with rare ready cycles, and a fixed one-in-eight hold.
    bit [1:0] stall_mode = 2'd0;
    int       stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            2'd0:    seg_bus.ready <= 1'b1;
            2'd1:    seg_bus.ready <= 1'($urandom_range(0, 1));
            2'd2:    seg_bus.ready <= ($urandom_range(0, 7) == 0);
            default: seg_bus.ready <= (stall_left[2:0] != 3'd0);
        endcase
    end

    // Offer one command and return at the edge where it is taken. The sender works in bursts;
    // at the start of each burst it may first drop valid. Within a burst valid stays
    // high from one item to the next, so it is never lowered and raised in the same step.
    task automatic send_command(input logic [2:0] code, input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd   <= code;
        cmd_bus.value <= value;
        do @(posedge i_clk); while (!cmd_bus.ready);
        items_sent++;
    endtask

    // Stop sending until every predicted serial item has come out of the block.
    task automatic wait_for_drain();
        cmd_bus.valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (owed_items != 0) @(posedge i_clk);
    endtask

    // Digit codes are mostly in the tables, with the occasional code past fifteen.
    function automatic logic [7:0] pick_digit();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(16, 255));
        return 8'($urandom_range(0, 15));
    endfunction

    // A print command with fitting content: hex and decimal take any byte, but decimal
    // is steered now and then above 159 so that the tens digit drops out.
    task automatic send_print();
        case ($urandom_range(0, 3))
            0: send_command(segl_pkg::CMD_HEX, 8'($urandom));
            1: begin
                if ($urandom_range(0, 4) == 0)
                    send_command(segl_pkg::CMD_DECIMAL, 8'($urandom_range(160, 255)));
                else
                    send_command(segl_pkg::CMD_DECIMAL, 8'($urandom_range(0, 159)));
            end
            2: send_command(segl_pkg::CMD_ONES, pick_digit());
            default: send_command(segl_pkg::CMD_TENS, pick_digit());
        endcase
    endtask

    initial begin
        cmd_bus.valid <= 1'b0;
        cmd_bus.cmd   <= segl_pkg::CMD_FILL;
        cmd_bus.value <= 8'h00;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The image straight out of reset, then fills at both extremes.
        send_command(segl_pkg::CMD_REFRESH, 8'h00);
        send_command(segl_pkg::CMD_FILL, 8'hff);
        send_command(segl_pkg::CMD_REFRESH, 8'hff);
        // Clear keeps only the masked bits of the first two bytes.
        send_command(segl_pkg::CMD_CLEAR, 8'h5a);
        send_command(segl_pkg::CMD_REFRESH, 8'h00);
        send_command(segl_pkg::CMD_FILL, 8'h00);
        // Single digits at the ends of the tables and just past them, where nothing is added.
        send_command(segl_pkg::CMD_ONES, 8'd0);
        send_command(segl_pkg::CMD_TENS, 8'd15);
        send_command(segl_pkg::CMD_REFRESH, 8'h00);
        send_command(segl_pkg::CMD_CLEAR, 8'h00);
        send_command(segl_pkg::CMD_ONES, 8'd16);
        send_command(segl_pkg::CMD_TENS, 8'd255);
        send_command(segl_pkg::CMD_ONES, 8'd15);
        send_command(segl_pkg::CMD_REFRESH, 8'h00);
        // Hex at both extremes of the byte.
        send_command(segl_pkg::CMD_FILL, 8'h00);
        send_command(segl_pkg::CMD_HEX, 8'hff);
        send_command(segl_pkg::CMD_HEX, 8'h00);
        send_command(segl_pkg::CMD_REFRESH, 8'h00);
        // Decimal on either side of 160, where the tens digit stops printing.
        send_command(segl_pkg::CMD_FILL, 8'h00);
        send_command(segl_pkg::CMD_DECIMAL, 8'd159);
        send_command(segl_pkg::CMD_REFRESH, 8'h00);
        send_command(segl_pkg::CMD_CLEAR, 8'h00);
        send_command(segl_pkg::CMD_DECIMAL, 8'd160);
        send_command(segl_pkg::CMD_DECIMAL, 8'd255);
        // The unused code must leave the image alone.
        send_command(CMD_UNUSED, 8'hff);
        send_command(segl_pkg::CMD_REFRESH, 8'h00);
        wait_for_drain();

        // Random part. Most of it is well-formed display updates: clear or fill, one or two
        // prints, then a refresh. The rest is single commands of any code and value.
        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                send_command(3'($urandom_range(0, 7)), 8'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0)
                    send_command(segl_pkg::CMD_FILL, 8'($urandom));
                else
                    send_command(segl_pkg::CMD_CLEAR, 8'($urandom));
                repeat ($urandom_range(1, 2)) send_print();
                send_command(segl_pkg::CMD_REFRESH, 8'($urandom));
            end
            // Now and then let the serial side empty completely before going on.
            if ($urandom_range(0, 40) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("segment_lcd_buffer_and_serial_loader_core regression: pass");
        else
            $display("segment_lcd_buffer_and_serial_loader_core regression: fail");
        $finish;
    end

endmodule
